// ===== rtl/sfa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared widths, register codes, pipeline control record and reciprocal
// table for the sliding-window frame average.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam int unsigned MAX_PIXELS = 4096;
  localparam int unsigned WINDOW_MAX = 16;

  localparam int unsigned POS_W   = $clog2(MAX_PIXELS);
  localparam int unsigned SLOT_W  = $clog2(WINDOW_MAX);
  localparam int unsigned HADDR_W = SLOT_W + POS_W;
  localparam int unsigned WIN_W   = 5;
  localparam int unsigned FP_W    = 13;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned PIX_W   = 3 * CH_W;
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned SUMS_W  = 3 * SUM_W;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned RECIP_W = FRAC_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned QD_W    = SUM_W + WIN_W;

  typedef enum logic [0:0] {
    REG_WINDOW_SIZE  = 1'b0,
    REG_FRAME_PIXELS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [SLOT_W-1:0] slot;
    logic              first;
    logic              full;
    logic [WIN_W-1:0]  divisor;
    logic              last;
  } pix_ctl_t;

  // floor(2^16 / d) for d = 1..16
  function automatic logic [RECIP_W-1:0] recip(input logic [WIN_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      5'd2:    r = 17'd32768;
      5'd3:    r = 17'd21845;
      5'd4:    r = 17'd16384;
      5'd5:    r = 17'd13107;
      5'd6:    r = 17'd10922;
      5'd7:    r = 17'd9362;
      5'd8:    r = 17'd8192;
      5'd9:    r = 17'd7281;
      5'd10:   r = 17'd6553;
      5'd11:   r = 17'd5957;
      5'd12:   r = 17'd5461;
      5'd13:   r = 17'd5041;
      5'd14:   r = 17'd4681;
      5'd15:   r = 17'd4369;
      5'd16:   r = 17'd4096;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sliding_window_frame_average.sv =====
// ----------------------------------------------------------------------------
// sliding_window_frame_average
// Per-pixel temporal moving average of RGB video over the last N frames.
//
//   port group   dir  handshake              payload
//   config       in   cfg_we_i               cfg_addr_i, cfg_wdata_i
//   pixel in     in   in_valid_i/in_ready_o  in_red_i, in_green_i, in_blue_i
//   average out  out  out_valid_o/out_ready_i avg_*_o, frame_end_o
//
// One pixel per clock sustained while out_ready_i accepts the results.
// Stages: memory read, sum update and write-back, reciprocal multiply,
// back-multiply, correction and rounding into the output register.
// No clearing pass after reset: the first frame loads the sums unread.
// A stalled output fills empty stages first, then backs up stage by stage.
// ----------------------------------------------------------------------------
module sliding_window_frame_average (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_addr_i,
  input  logic [sfa_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sfa_pkg::CH_W-1:0]  in_red_i,
  input  logic [sfa_pkg::CH_W-1:0]  in_green_i,
  input  logic [sfa_pkg::CH_W-1:0]  in_blue_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sfa_pkg::CH_W-1:0]  avg_red_o,
  output logic [sfa_pkg::CH_W-1:0]  avg_green_o,
  output logic [sfa_pkg::CH_W-1:0]  avg_blue_o,
  output logic                      frame_end_o
);

  sfa_pkg::pix_ctl_t          ctl0;
  sfa_pkg::pix_ctl_t          ctl1;
  logic [sfa_pkg::SUMS_W-1:0] sums1;
  logic                       v1_q, v2_q, v3_q, v4_q;
  logic                       l2_q, l3_q, l4_q;
  logic [sfa_pkg::WIN_W-1:0]  div1;
  logic                       en1, en2, en3, en4;
  logic                       accept;
  logic                       adv1;

  assign en4    = !v4_q || out_ready_i;
  assign en3    = !v3_q || en4;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign accept = in_valid_i && en1;
  assign adv1   = v1_q && en2;
  assign div1   = ctl1.divisor;

  sfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .ctl_o       (ctl0)
  );

  sfa_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .en1_i    (en1),
    .adv1_i   (adv1),
    .ctl_i    (ctl0),
    .px_i     ({in_red_i, in_green_i, in_blue_i}),
    .ctl_o    (ctl1),
    .sum_o    (sums1)
  );

  sfa_div u_div_red (
    .clk_i     (clk_i),
    .en2_i     (en2),
    .en3_i     (en3),
    .en4_i     (en4),
    .sum_i     (sums1[2*sfa_pkg::SUM_W +: sfa_pkg::SUM_W]),
    .divisor_i (div1),
    .avg_o     (avg_red_o)
  );

  sfa_div u_div_green (
    .clk_i     (clk_i),
    .en2_i     (en2),
    .en3_i     (en3),
    .en4_i     (en4),
    .sum_i     (sums1[sfa_pkg::SUM_W +: sfa_pkg::SUM_W]),
    .divisor_i (div1),
    .avg_o     (avg_green_o)
  );

  sfa_div u_div_blue (
    .clk_i     (clk_i),
    .en2_i     (en2),
    .en3_i     (en3),
    .en4_i     (en4),
    .sum_i     (sums1[0 +: sfa_pkg::SUM_W]),
    .divisor_i (div1),
    .avg_o     (avg_blue_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      l2_q <= ctl1.last;
    end
    if (en3) begin
      l3_q <= l2_q;
    end
    if (en4) begin
      l4_q <= l3_q;
    end
  end

  assign in_ready_o  = en1;
  assign out_valid_o = v4_q;
  assign frame_end_o = l4_q;

endmodule

// ===== rtl/sfa_ram.sv =====
// ----------------------------------------------------------------------------
// sfa_ram
// Generic single-write, single-read synchronous RAM with registered,
// read-first output. Output holds while read enable is low.
// ----------------------------------------------------------------------------
module sfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfa_ctrl
// Configuration registers and frame bookkeeping: pixel position, ring slot
// and frame count. Produces the per-request control record.
// ----------------------------------------------------------------------------
module sfa_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_addr_i,
  input  logic [sfa_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                     accept_i,
  output sfa_pkg::pix_ctl_t        ctl_o
);

  logic [sfa_pkg::WIN_W-1:0]  window_q, window_d;
  logic [sfa_pkg::FP_W-1:0]   fpix_q, fpix_d;
  logic [sfa_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [sfa_pkg::SLOT_W-1:0] head_q, head_d;
  logic [sfa_pkg::WIN_W-1:0]  frames_q, frames_d;

  logic [sfa_pkg::WIN_W-1:0]  win_eff;
  logic [sfa_pkg::FP_W-1:0]   fp_eff;
  logic [sfa_pkg::FP_W-1:0]   fp_m1;
  logic [sfa_pkg::POS_W-1:0]  pos_c;
  logic [sfa_pkg::SLOT_W-1:0] slot_c;
  logic [sfa_pkg::WIN_W-1:0]  slot_inc;
  logic                       full;
  logic                       last;

  always_comb begin
    if (window_q == '0) begin
      win_eff = sfa_pkg::WIN_W'(1);
    end else if (window_q > sfa_pkg::WIN_W'(sfa_pkg::WINDOW_MAX)) begin
      win_eff = sfa_pkg::WIN_W'(sfa_pkg::WINDOW_MAX);
    end else begin
      win_eff = window_q;
    end
    if (fpix_q == '0) begin
      fp_eff = sfa_pkg::FP_W'(1);
    end else if (fpix_q > sfa_pkg::FP_W'(sfa_pkg::MAX_PIXELS)) begin
      fp_eff = sfa_pkg::FP_W'(sfa_pkg::MAX_PIXELS);
    end else begin
      fp_eff = fpix_q;
    end
    fp_m1    = fp_eff - sfa_pkg::FP_W'(1);
    pos_c    = (sfa_pkg::FP_W'(pos_q) >= fp_eff) ? fp_m1[sfa_pkg::POS_W-1:0] : pos_q;
    slot_c   = (sfa_pkg::WIN_W'(head_q) >= win_eff) ? '0 : head_q;
    slot_inc = sfa_pkg::WIN_W'(slot_c) + sfa_pkg::WIN_W'(1);
    full     = frames_q >= win_eff;
    last     = (sfa_pkg::FP_W'(pos_c) + sfa_pkg::FP_W'(1)) >= fp_eff;

    ctl_o.pos     = pos_c;
    ctl_o.slot    = slot_c;
    ctl_o.first   = frames_q == '0;
    ctl_o.full    = full;
    ctl_o.divisor = full ? win_eff : frames_q + sfa_pkg::WIN_W'(1);
    ctl_o.last    = last;
  end

  always_comb begin
    window_d = window_q;
    fpix_d   = fpix_q;
    pos_d    = pos_q;
    head_d   = head_q;
    frames_d = frames_q;
    if (cfg_we_i) begin
      unique case (sfa_pkg::cfg_reg_e'(cfg_addr_i))
        sfa_pkg::REG_WINDOW_SIZE:  window_d = cfg_wdata_i[sfa_pkg::WIN_W-1:0];
        sfa_pkg::REG_FRAME_PIXELS: fpix_d   = cfg_wdata_i[sfa_pkg::FP_W-1:0];
        default:                   window_d = window_q;
      endcase
      pos_d    = '0;
      head_d   = '0;
      frames_d = '0;
    end else if (accept_i) begin
      if (last) begin
        pos_d  = '0;
        head_d = (slot_inc >= win_eff) ? '0 : slot_inc[sfa_pkg::SLOT_W-1:0];
        if (!full) begin
          frames_d = frames_q + sfa_pkg::WIN_W'(1);
        end
      end else begin
        pos_d  = pos_c + sfa_pkg::POS_W'(1);
        head_d = slot_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= sfa_pkg::WIN_W'(sfa_pkg::WINDOW_MAX);
      fpix_q   <= sfa_pkg::FP_W'(sfa_pkg::MAX_PIXELS);
      pos_q    <= '0;
      head_q   <= '0;
      frames_q <= '0;
    end else begin
      window_q <= window_d;
      fpix_q   <= fpix_d;
      pos_q    <= pos_d;
      head_q   <= head_d;
      frames_q <= frames_d;
    end
  end

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> (ctl_o.divisor != '0) &&
                 (ctl_o.divisor <= sfa_pkg::WIN_W'(sfa_pkg::WINDOW_MAX)))
    else $error("divisor out of range");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> sfa_pkg::FP_W'(ctl_o.pos) < fp_eff)
    else $error("pixel position beyond frame");

  a_frames_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q <= win_eff || $past(cfg_we_i))
    else $error("frame count beyond window");

endmodule

// ===== rtl/sfa_accum.sv =====
// ----------------------------------------------------------------------------
// sfa_accum
// History ring and running-sum memories. Reads both on request, updates the
// per-position sums as the request moves on, forwarding the previous write.
// ----------------------------------------------------------------------------
module sfa_accum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       en1_i,
  input  logic                       adv1_i,
  input  sfa_pkg::pix_ctl_t          ctl_i,
  input  logic [sfa_pkg::PIX_W-1:0]  px_i,
  output sfa_pkg::pix_ctl_t          ctl_o,
  output logic [sfa_pkg::SUMS_W-1:0] sum_o
);

  sfa_pkg::pix_ctl_t                ctl_q;
  logic [sfa_pkg::PIX_W-1:0]        px_q;
  logic [sfa_pkg::PIX_W-1:0]        hist_rd;
  logic [sfa_pkg::SUMS_W-1:0]       sum_rd;
  logic [sfa_pkg::SUMS_W-1:0]       sum_prev;
  logic [sfa_pkg::SUMS_W-1:0]       sum_new;
  logic [sfa_pkg::HADDR_W-1:0]      haddr;
  logic                             fwd_v_q;
  logic [sfa_pkg::POS_W-1:0]        fwd_pos_q;
  logic [sfa_pkg::SUMS_W-1:0]       fwd_data_q;
  logic                             fwd_hit;

  assign haddr = {ctl_i.slot, ctl_i.pos};

  sfa_ram #(
    .WIDTH (sfa_pkg::PIX_W),
    .DEPTH (sfa_pkg::WINDOW_MAX * sfa_pkg::MAX_PIXELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (accept_i),
    .waddr_i (haddr),
    .wdata_i (px_i),
    .re_i    (en1_i),
    .raddr_i (haddr),
    .rdata_o (hist_rd)
  );

  sfa_ram #(
    .WIDTH (sfa_pkg::SUMS_W),
    .DEPTH (sfa_pkg::MAX_PIXELS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (adv1_i),
    .waddr_i (ctl_q.pos),
    .wdata_i (sum_new),
    .re_i    (en1_i),
    .raddr_i (ctl_i.pos),
    .rdata_o (sum_rd)
  );

  assign fwd_hit  = fwd_v_q && (fwd_pos_q == ctl_q.pos);
  assign sum_prev = fwd_hit ? fwd_data_q : sum_rd;

  always_comb begin
    logic [sfa_pkg::CH_W-1:0]  pix;
    logic [sfa_pkg::CH_W-1:0]  leave;
    logic [sfa_pkg::SUM_W:0]   tot;
    sum_new = '0;
    for (int c = 0; c < 3; c++) begin
      pix   = px_q[(2-c)*sfa_pkg::CH_W +: sfa_pkg::CH_W];
      leave = hist_rd[(2-c)*sfa_pkg::CH_W +: sfa_pkg::CH_W];
      tot   = {1'b0, sum_prev[(2-c)*sfa_pkg::SUM_W +: sfa_pkg::SUM_W]} +
              (sfa_pkg::SUM_W+1)'(pix);
      if (ctl_q.full) begin
        tot = (tot >= (sfa_pkg::SUM_W+1)'(leave)) ? tot - (sfa_pkg::SUM_W+1)'(leave) : '0;
      end
      sum_new[(2-c)*sfa_pkg::SUM_W +: sfa_pkg::SUM_W] =
        ctl_q.first ? sfa_pkg::SUM_W'(pix) : tot[sfa_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      ctl_q      <= ctl_i;
      px_q       <= px_i;
      fwd_pos_q  <= ctl_q.pos;
      fwd_data_q <= sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (en1_i) begin
      fwd_v_q <= adv1_i;
    end
  end

  assign ctl_o = ctl_q;
  assign sum_o = sum_new;

endmodule

// ===== rtl/sfa_div.sv =====
// ----------------------------------------------------------------------------
// sfa_div
// Three-stage divide of a 12-bit sum by 1..16: reciprocal multiply,
// back-multiply, then single correction, round half to even and clamp.
// ----------------------------------------------------------------------------
module sfa_div (
  input  logic                      clk_i,
  input  logic                      en2_i,
  input  logic                      en3_i,
  input  logic                      en4_i,
  input  logic [sfa_pkg::SUM_W-1:0] sum_i,
  input  logic [sfa_pkg::WIN_W-1:0] divisor_i,
  output logic [sfa_pkg::CH_W-1:0]  avg_o
);

  logic [sfa_pkg::PROD_W-1:0] prod2_q;
  logic [sfa_pkg::SUM_W-1:0]  sum2_q, sum3_q;
  logic [sfa_pkg::WIN_W-1:0]  d2_q, d3_q;
  logic [sfa_pkg::SUM_W-1:0]  q3_q;
  logic [sfa_pkg::QD_W-1:0]   qd3_q;
  logic [sfa_pkg::QD_W-1:0]   qd;
  logic [sfa_pkg::CH_W-1:0]   avg_q;
  logic [sfa_pkg::SUM_W-1:0]  q_est;
  logic [sfa_pkg::SUM_W-1:0]  rem;
  logic [sfa_pkg::SUM_W:0]    q_fin;
  logic [sfa_pkg::WIN_W:0]    r_fin;
  logic                       rnd_up;

  assign q_est = prod2_q[sfa_pkg::FRAC_W +: sfa_pkg::SUM_W];
  assign qd    = sfa_pkg::QD_W'(q_est) * sfa_pkg::QD_W'(d2_q);

  always_comb begin
    rem = sum3_q - qd3_q[sfa_pkg::SUM_W-1:0];
    if (rem >= sfa_pkg::SUM_W'(d3_q)) begin
      q_fin = (sfa_pkg::SUM_W+1)'(q3_q) + (sfa_pkg::SUM_W+1)'(1);
      r_fin = (sfa_pkg::WIN_W+1)'(rem - sfa_pkg::SUM_W'(d3_q)) << 1;
    end else begin
      q_fin = (sfa_pkg::SUM_W+1)'(q3_q);
      r_fin = (sfa_pkg::WIN_W+1)'(rem[sfa_pkg::WIN_W-1:0]) << 1;
    end
    rnd_up = (r_fin > (sfa_pkg::WIN_W+1)'(d3_q)) ||
             ((r_fin == (sfa_pkg::WIN_W+1)'(d3_q)) && q_fin[0]);
    q_fin  = q_fin + (sfa_pkg::SUM_W+1)'(rnd_up);
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      sum2_q  <= sum_i;
      d2_q    <= divisor_i;
      prod2_q <= sfa_pkg::PROD_W'(sum_i) * sfa_pkg::PROD_W'(sfa_pkg::recip(divisor_i));
    end
    if (en3_i) begin
      sum3_q <= sum2_q;
      d3_q   <= d2_q;
      q3_q   <= q_est;
      qd3_q  <= qd;
    end
    if (en4_i) begin
      avg_q <= (q_fin > (sfa_pkg::SUM_W+1)'(255)) ? 8'd255 : q_fin[sfa_pkg::CH_W-1:0];
    end
  end

  assign avg_o = avg_q;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding-window frame average. Drives RGB pixel
// requests with bursty valid, stalls the result side, and checks every average
// and frame end against a per-position window predictor. It covers the power-up
// settings, clamped register values, rounding ties, restart on register write
// and random window and frame sizes, mostly long enough to fill the window.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RANDOM_PIXELS = 680;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT   = 2000;

  typedef struct packed {
    logic [sfa_pkg::CH_W-1:0] red;
    logic [sfa_pkg::CH_W-1:0] green;
    logic [sfa_pkg::CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [sfa_pkg::CH_W-1:0] red;
    logic [sfa_pkg::CH_W-1:0] green;
    logic [sfa_pkg::CH_W-1:0] blue;
    logic                     frame_end;
  } avg_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_CADENCE
  } rx_pace_e;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [0:0]                cfg_addr_i  = sfa_pkg::REG_WINDOW_SIZE;
  logic [sfa_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic [sfa_pkg::CH_W-1:0]  in_red_i    = '0;
  logic [sfa_pkg::CH_W-1:0]  in_green_i  = '0;
  logic [sfa_pkg::CH_W-1:0]  in_blue_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [sfa_pkg::CH_W-1:0]  avg_red_o;
  logic [sfa_pkg::CH_W-1:0]  avg_green_o;
  logic [sfa_pkg::CH_W-1:0]  avg_blue_o;
  logic                      frame_end_o;

  sliding_window_frame_average dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .avg_red_o   (avg_red_o),
    .avg_green_o (avg_green_o),
    .avg_blue_o  (avg_blue_o),
    .frame_end_o (frame_end_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // window predictor state
  bit [sfa_pkg::PIX_W-1:0] frame_ring [sfa_pkg::WINDOW_MAX * sfa_pkg::MAX_PIXELS];
  bit [sfa_pkg::SUM_W-1:0] chan_sum [sfa_pkg::MAX_PIXELS][3];
  logic [sfa_pkg::WIN_W-1:0] win_reg = sfa_pkg::WIN_W'(16);
  logic [sfa_pkg::FP_W-1:0]  fp_reg  = sfa_pkg::FP_W'(4096);
  int unsigned cur_pos     = 0;
  int unsigned frames_done = 0;
  int unsigned cur_slot    = 0;

  avg_t        pending_averages [$];
  avg_t        head_avg;
  int unsigned error_count = 0;
  int unsigned burst_left  = 0;
  int unsigned quiet_cycles = 0;
  rx_pace_e    rx_pace = RX_ALWAYS;
  int unsigned pace_left = 0;
  int unsigned pace_tick = 0;

  task automatic flag_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [sfa_pkg::CH_W-1:0] round_half_even(input int unsigned s,
                                                               input int unsigned d);
    int unsigned q;
    int unsigned r;
    q = s / d;
    r = s % d;
    if (2 * r > d || (2 * r == d && q[0])) q++;
    return (q > 255) ? sfa_pkg::CH_W'(255) : sfa_pkg::CH_W'(q);
  endfunction

  function automatic avg_t average_pixel(input rgb_t px);
    int unsigned win_eff, fp_eff, pos, slot, divisor, s, leave;
    bit full;
    bit [sfa_pkg::PIX_W-1:0] old;
    logic [sfa_pkg::CH_W-1:0] chan_in [3];
    logic [sfa_pkg::CH_W-1:0] chan_out [3];
    avg_t res;
    win_eff = (win_reg == 0) ? 1 :
              (win_reg > sfa_pkg::WINDOW_MAX) ? sfa_pkg::WINDOW_MAX : win_reg;
    fp_eff  = (fp_reg == 0) ? 1 :
              (fp_reg > sfa_pkg::MAX_PIXELS) ? sfa_pkg::MAX_PIXELS : fp_reg;
    pos  = (cur_pos >= fp_eff) ? fp_eff - 1 : cur_pos;
    slot = (cur_slot >= win_eff) ? 0 : cur_slot;
    full = frames_done >= win_eff;
    old  = frame_ring[slot * sfa_pkg::MAX_PIXELS + pos];
    divisor = full ? win_eff : frames_done + 1;
    chan_in[0] = px.red;
    chan_in[1] = px.green;
    chan_in[2] = px.blue;
    for (int c = 0; c < 3; c++) begin
      if (frames_done == 0) begin
        s = chan_in[c];
      end else begin
        s = chan_sum[pos][c] + chan_in[c];
        if (full) begin
          leave = (old >> (16 - 8 * c)) & 32'hFF;
          s = (s >= leave) ? s - leave : 0;
        end
      end
      s = s & 32'hFFF;
      chan_sum[pos][c] = sfa_pkg::SUM_W'(s);
      chan_out[c] = round_half_even(s, divisor);
    end
    frame_ring[slot * sfa_pkg::MAX_PIXELS + pos] = px;
    res.red       = chan_out[0];
    res.green     = chan_out[1];
    res.blue      = chan_out[2];
    res.frame_end = (pos + 1 >= fp_eff);
    if (res.frame_end) begin
      cur_pos  = 0;
      cur_slot = (slot + 1 >= win_eff) ? 0 : slot + 1;
      if (frames_done < win_eff) frames_done++;
    end else begin
      cur_pos  = pos + 1;
      cur_slot = slot;
    end
    return res;
  endfunction

  function automatic logic [sfa_pkg::CH_W-1:0] pick_channel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return sfa_pkg::CH_W'($urandom());
    endcase
  endfunction

  task automatic push_pixel(input rgb_t px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_red_i   <= px.red;
    in_green_i <= px.green;
    in_blue_i  <= px.blue;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_averages.push_back(average_pixel(px));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input sfa_pkg::cfg_reg_e idx,
                                input logic [sfa_pkg::CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sfa_pkg::REG_WINDOW_SIZE) win_reg = val[sfa_pkg::WIN_W-1:0];
    else fp_reg = val[sfa_pkg::FP_W-1:0];
    cur_pos     = 0;
    frames_done = 0;
    cur_slot    = 0;
    @(posedge clk_i);
  endtask

  task automatic test_power_up();
    rgb_t pattern [5];
    pattern = '{'{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'hAA, 8'h55, 8'hAA},
                '{8'h55, 8'hAA, 8'h55}, '{8'h01, 8'h80, 8'hFE}};
    foreach (pattern[i]) push_pixel(pattern[i]);
    wait_idle();
  endtask

  task automatic test_clamped_registers();
    rgb_t px;
    write_register(sfa_pkg::REG_WINDOW_SIZE, 13'h1FE0);
    write_register(sfa_pkg::REG_FRAME_PIXELS, 13'h0000);
    repeat (4) begin
      px = '{pick_channel(), pick_channel(), pick_channel()};
      push_pixel(px);
    end
    wait_idle();
    write_register(sfa_pkg::REG_WINDOW_SIZE, 13'h001F);
    write_register(sfa_pkg::REG_FRAME_PIXELS, 13'h1FFF);
    repeat (2) begin
      px = '{pick_channel(), pick_channel(), pick_channel()};
      push_pixel(px);
    end
    wait_idle();
  endtask

  task automatic test_rounding_ties();
    rgb_t px;
    write_register(sfa_pkg::REG_WINDOW_SIZE, sfa_pkg::CFG_W'(2));
    write_register(sfa_pkg::REG_FRAME_PIXELS, sfa_pkg::CFG_W'(1));
    for (int k = 0; k < 8; k++) begin
      px = '{sfa_pkg::CH_W'(k), sfa_pkg::CH_W'(255 - k), sfa_pkg::CH_W'(k * 37)};
      push_pixel(px);
    end
    wait_idle();
  endtask

  task automatic test_restart_mid_frame();
    rgb_t px;
    write_register(sfa_pkg::REG_WINDOW_SIZE, sfa_pkg::CFG_W'(3));
    write_register(sfa_pkg::REG_FRAME_PIXELS, sfa_pkg::CFG_W'(3));
    repeat (2) begin
      px = '{pick_channel(), pick_channel(), pick_channel()};
      push_pixel(px);
    end
    wait_idle();
    write_register(sfa_pkg::REG_FRAME_PIXELS, sfa_pkg::CFG_W'(3));
    repeat (3) begin
      px = '{pick_channel(), pick_channel(), pick_channel()};
      push_pixel(px);
    end
    wait_idle();
  endtask

  task automatic test_random_streams();
    int unsigned sent, n, win_eff, fp_eff;
    logic [sfa_pkg::WIN_W-1:0] win;
    logic [sfa_pkg::FP_W-1:0]  fp;
    logic [sfa_pkg::CFG_W-1:0] win_word;
    bit big;
    rgb_t px;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       win = '0;
        1:       win = sfa_pkg::WIN_W'(31);
        2:       win = sfa_pkg::WIN_W'($urandom_range(17, 30));
        default: win = sfa_pkg::WIN_W'($urandom_range(1, 16));
      endcase
      win_eff = (win == 0) ? 1 : (win > sfa_pkg::WINDOW_MAX) ? sfa_pkg::WINDOW_MAX : win;
      big = 1'b0;
      case ($urandom_range(0, 19))
        0: fp = '0;
        1: begin
          fp  = sfa_pkg::FP_W'($urandom_range(4096, 8191));
          big = 1'b1;
        end
        2, 3:    fp = sfa_pkg::FP_W'($urandom_range(13, 64));
        default: fp = sfa_pkg::FP_W'($urandom_range(1, 12));
      endcase
      fp_eff = (fp == 0) ? 1 : (fp > sfa_pkg::MAX_PIXELS) ? sfa_pkg::MAX_PIXELS : fp;
      if (!big && win_eff * fp_eff > 160) begin
        fp = sfa_pkg::FP_W'($urandom_range(1, 160 / win_eff));
        fp_eff = fp;
      end
      if (big) n = $urandom_range(1, 24);
      else n = (win_eff + $urandom_range(0, 3)) * fp_eff + $urandom_range(0, fp_eff - 1);
      win_word = {8'($urandom()), win};
      if ($urandom_range(0, 1) == 0) begin
        write_register(sfa_pkg::REG_WINDOW_SIZE, win_word);
        write_register(sfa_pkg::REG_FRAME_PIXELS, fp);
      end else begin
        write_register(sfa_pkg::REG_FRAME_PIXELS, fp);
        write_register(sfa_pkg::REG_WINDOW_SIZE, win_word);
      end
      repeat (n) begin
        px = '{pick_channel(), pick_channel(), pick_channel()};
        push_pixel(px);
      end
      sent += n;
      wait_idle();
    end
  endtask

  always @(posedge clk_i) begin
    if (pace_left == 0) begin
      rx_pace   = rx_pace_e'($urandom_range(0, 3));
      pace_left = $urandom_range(30, 200);
    end
    pace_left--;
    pace_tick++;
    case (rx_pace)
      RX_ALWAYS: out_ready_i <= 1'b1;
      RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_RARELY: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= (pace_tick % 7) < 4;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_averages.size() == 0) begin
        flag_error("average returned with no pixel pending");
      end else begin
        head_avg = pending_averages.pop_front();
        if (avg_red_o !== head_avg.red)
          flag_error($sformatf("avg_red %0d, want %0d", avg_red_o, head_avg.red));
        if (avg_green_o !== head_avg.green)
          flag_error($sformatf("avg_green %0d, want %0d", avg_green_o, head_avg.green));
        if (avg_blue_o !== head_avg.blue)
          flag_error($sformatf("avg_blue %0d, want %0d", avg_blue_o, head_avg.blue));
        if (frame_end_o !== head_avg.frame_end)
          flag_error($sformatf("frame_end %0b, want %0b", frame_end_o, head_avg.frame_end));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_power_up();
    test_clamped_registers();
    test_rounding_ties();
    test_restart_mid_frame();
    test_random_streams();
    wait_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
